>>> hdl/amp2d_pkg.sv
// Adaptive 2-D max pool: shared constants, item and control types, helpers.
// No dependencies; every other file imports this package.
package amp2d_pkg;

  localparam int MAX_IN_H    = 64;
  localparam int MAX_IN_W    = 64;
  localparam int MAX_OUT_DIM = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int MAX_IN_DIM  = (MAX_IN_H > MAX_IN_W) ? MAX_IN_H : MAX_IN_W;
  localparam int STORE_DEPTH = MAX_IN_H * MAX_IN_W;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int VAL_W     = 16;
  localparam int POS_W     = 12;
  localparam int CELL_W    = 6;

  // bound numerators reach out*in + out - 1
  localparam int NUM_W      = $clog2(MAX_OUT_DIM * MAX_IN_DIM + MAX_OUT_DIM);
  localparam int STEP_CNT_W = $clog2(NUM_W);
  localparam int N_LANES    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IN_H  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_W  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_H = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_W = 2'd3;

  localparam int LANE_H0 = 0;
  localparam int LANE_H1 = 1;
  localparam int LANE_W0 = 2;
  localparam int LANE_W1 = 3;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [VAL_W-1:0]  sample;
    logic [POS_W-1:0]         sample_pos;
    logic [CELL_W-1:0]        cell_row;
    logic [CELL_W-1:0]        cell_col;
  } amp2d_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic [POS_W-1:0]        max_pos;
  } amp2d_out_t;

  typedef struct packed {
    logic latch_query;
    logic store;
    logic div_load;
    logic div_step;
    logic base_load;
    logic walk;
    logic out_load;
  } amp2d_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic walk_last;
    logic out_free;
  } amp2d_status_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> hdl/amp2d_ctrl.sv
// Adaptive 2-D max pool: sequencing state machine.
// Depends on amp2d_pkg; drives commands into amp2d_dp.
module amp2d_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  amp2d_pkg::kind_e        in_kind_i,
  input  amp2d_pkg::amp2d_status_t status_i,
  output amp2d_pkg::amp2d_cmd_t   cmd_o,
  output logic                    busy_o
);
  import amp2d_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_STORE) begin
            cmd_o.store = 1'b1;
          end else if (status_i.in_grid) begin
            cmd_o.latch_query = 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(NUM_W - 1)) state_d = S_BASE;
      end
      S_BASE: begin
        cmd_o.base_load = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hdl/amp2d_dp.sv
// Adaptive 2-D max pool: config registers, plane store, bound dividers,
// window walker, running maximum and output register. Depends on amp2d_pkg.
module amp2d_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [amp2d_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [amp2d_pkg::CFG_W-1:0]     cfg_data_i,
  input  amp2d_pkg::amp2d_in_t     in_item_i,
  input  amp2d_pkg::amp2d_cmd_t    cmd_i,
  output amp2d_pkg::amp2d_status_t status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output amp2d_pkg::amp2d_out_t    out_item_o
);
  import amp2d_pkg::*;

  logic [CFG_W-1:0] in_h_q, in_w_q, out_h_q, out_w_q;
  logic [CFG_W-1:0] ih, iw, oh, ow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_h_q  <= CFG_W'(64);
      in_w_q  <= CFG_W'(64);
      out_h_q <= CFG_W'(1);
      out_w_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IN_H:  in_h_q  <= cfg_data_i;
        REG_IN_W:  in_w_q  <= cfg_data_i;
        REG_OUT_H: out_h_q <= cfg_data_i;
        REG_OUT_W: out_w_q <= cfg_data_i;
      endcase
    end
  end

  assign ih = clamp_dim(in_h_q, CFG_W'(MAX_IN_H));
  assign iw = clamp_dim(in_w_q, CFG_W'(MAX_IN_W));
  assign oh = clamp_dim(out_h_q, CFG_W'(MAX_OUT_DIM));
  assign ow = clamp_dim(out_w_q, CFG_W'(MAX_OUT_DIM));

  assign status_o.in_grid = ({1'b0, in_item_i.cell_row} < oh) &&
                            ({1'b0, in_item_i.cell_col} < ow);

  // plane store
  logic signed [SAMPLE_BITS-1:0] plane_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          wr_ok;

  assign wr_ok = ({1'b0, in_item_i.sample_pos} < (POS_W+1)'(STORE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && wr_ok) begin
      plane_q[in_item_i.sample_pos[ADDR_W-1:0]] <= SAMPLE_BITS'(in_item_i.sample);
    end
    rdata_q <= plane_q[rd_addr];
  end

  // window bound dividers, four restoring lanes stepped together
  logic [CELL_W-1:0] row_q, col_q;
  logic [NUM_W-1:0]  num   [N_LANES];
  logic [CFG_W-1:0]  den   [N_LANES];
  logic [NUM_W-1:0]  quo_q [N_LANES];
  logic [NUM_W-1:0]  quo_d [N_LANES];
  logic [CFG_W-1:0]  rem_q [N_LANES];
  logic [CFG_W-1:0]  rem_d [N_LANES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_query) begin
      row_q <= in_item_i.cell_row;
      col_q <= in_item_i.cell_col;
    end
  end

  always_comb begin
    num[LANE_H0] = NUM_W'(row_q) * NUM_W'(ih);
    num[LANE_H1] = (NUM_W'(row_q) + NUM_W'(1)) * NUM_W'(ih) + NUM_W'(oh) - NUM_W'(1);
    num[LANE_W0] = NUM_W'(col_q) * NUM_W'(iw);
    num[LANE_W1] = (NUM_W'(col_q) + NUM_W'(1)) * NUM_W'(iw) + NUM_W'(ow) - NUM_W'(1);
    den[LANE_H0] = oh;
    den[LANE_H1] = oh;
    den[LANE_W0] = ow;
    den[LANE_W1] = ow;
  end

  always_comb begin
    logic [CFG_W:0] shifted;
    logic [CFG_W:0] trial;
    for (int i = 0; i < N_LANES; i++) begin
      shifted = {rem_q[i], quo_q[i][NUM_W-1]};
      trial   = shifted - {1'b0, den[i]};
      if (!trial[CFG_W]) begin
        rem_d[i] = trial[CFG_W-1:0];
        quo_d[i] = {quo_q[i][NUM_W-2:0], 1'b1};
      end else begin
        rem_d[i] = shifted[CFG_W-1:0];
        quo_d[i] = {quo_q[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LANES; i++) begin
      if (cmd_i.div_load) begin
        quo_q[i] <= num[i];
        rem_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        quo_q[i] <= quo_d[i];
        rem_q[i] <= rem_d[i];
      end
    end
  end

  // window walker
  logic [CFG_W-1:0]  h0, h1, w0, w1;
  logic [CFG_W-1:0]  h_q, w_q;
  logic [ADDR_W-1:0] rb_q;
  logic              row_end;

  assign h0 = quo_q[LANE_H0][CFG_W-1:0];
  assign h1 = quo_q[LANE_H1][CFG_W-1:0];
  assign w0 = quo_q[LANE_W0][CFG_W-1:0];
  assign w1 = quo_q[LANE_W1][CFG_W-1:0];

  assign rd_addr  = rb_q + ADDR_W'(w_q);
  assign row_end  = ((w_q + CFG_W'(1)) == w1);
  assign status_o.walk_last = row_end && ((h_q + CFG_W'(1)) == h1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.base_load) begin
      h_q  <= h0;
      w_q  <= w0;
      rb_q <= ADDR_W'(h0) * ADDR_W'(iw);
    end else if (cmd_i.walk) begin
      if (row_end) begin
        w_q  <= w0;
        h_q  <= h_q + CFG_W'(1);
        rb_q <= rb_q + ADDR_W'(iw);
      end else begin
        w_q  <= w_q + CFG_W'(1);
      end
    end
  end

  // running maximum, one read behind the walker
  logic                          rd_vld_q, first_q;
  logic [ADDR_W-1:0]             rpos_q, bpos_q;
  logic signed [SAMPLE_BITS-1:0] best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk;
      if (cmd_i.base_load) first_q <= 1'b1;
      else if (rd_vld_q)   first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rpos_q <= rd_addr;
    if (rd_vld_q && (first_q || (rdata_q > best_q))) begin
      best_q <= rdata_q;
      bpos_q <= rpos_q;
    end
  end

  // output register
  logic       out_valid_q;
  amp2d_out_t out_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.max_value <= VAL_W'(best_q);
      out_q.max_pos   <= POS_W'(bpos_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hdl/adaptive_max_pool_2d_top.sv
// Store item: next item accepted in the following cycle.
// Query: load, bound division over NUM_W (13) quotient bits, setup, window walk, drain;
// result shows once the output is free, in the same cycle the next item is accepted.
// The walk reads one store entry per cycle over the single memory read port.
// Reset (async, low) sets dims 64x64 -> 1x1; the plane store is not cleared.
module adaptive_max_pool_2d_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [amp2d_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [amp2d_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  amp2d_pkg::amp2d_in_t     in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output amp2d_pkg::amp2d_out_t    out_item_o
);
  import amp2d_pkg::*;

  amp2d_cmd_t    cmd;
  amp2d_status_t status;
  logic          busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  amp2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  amp2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> hdl/amp2d_checker.sv
// Adaptive 2-D max pool: port-level checks, bound to the top level.
// Depends on amp2d_pkg and adaptive_max_pool_2d_top.
module amp2d_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [amp2d_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [amp2d_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input amp2d_pkg::amp2d_in_t     in_item_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input amp2d_pkg::amp2d_out_t    out_item_o
);
  import amp2d_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_store_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.kind == KIND_STORE) |=> !in_stall_o)
    else $error("store item left the block busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("new result shown while query still running");

endmodule

bind adaptive_max_pool_2d_top amp2d_checker u_amp2d_checker (.*);
